/* hw/rtl/wbh_pkg.sv */
// Shared constants, codes, control structs and helper function of the weighted bin histogram.
`timescale 1ns / 1ps

package wbh_pkg;

	localparam int SUM_W           = 36;
	localparam int PROB_W          = 18;
	localparam int VAL_W           = 16;
	localparam int Q_W             = 17;
	localparam int NUM_THRESH      = 7;
	localparam int CFG_IDX_W       = 3;
	localparam int OP_W            = 2;
	localparam int STATUS_W        = 2;
	localparam int BIN_OUT_W       = 3;
	localparam int OUT_COUNT_W     = 20;
	localparam int DEF_NUM_BINS    = 8;
	localparam int DEF_COUNT_WIDTH = 20;
	localparam int DIV_STEPS       = Q_W;
	localparam int DIV_CNT_W       = $clog2(DIV_STEPS + 1);

	localparam logic [Q_W-1:0] ONE_Q16 = 17'h10000;

	localparam logic [OP_W-1:0] OP_INSERT   = 2'd0;
	localparam logic [OP_W-1:0] OP_FINALIZE = 2'd1;
	localparam logic [OP_W-1:0] OP_QUERY    = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] ST_RANGE  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_REJECT = 2'd2;
	localparam logic [STATUS_W-1:0] ST_ZERO   = 2'd3;

	localparam logic signed [VAL_W-1:0] THRESH_RESET [NUM_THRESH] = '{
		-16'sd12288, -16'sd4096, -16'sd2048, 16'sd0, 16'sd2048, 16'sd4096, 16'sd12288
	};

	// Commands from the sequencer to the datapath.
	typedef struct packed {
		logic accept;
		logic rd_en;
		logic rd_fin;
		logic exec;
		logic div_start;
		logic fin_wr;
		logic fin_done;
	} cmd_t;

	// Status from the datapath to the sequencer.
	typedef struct packed {
		logic start_fin;
		logic finalized;
		logic div_done;
	} sts_t;

	function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
	                                             input logic [Q_W-1:0] b);
		logic [SUM_W:0] s;
		s = {1'b0, a} + {{(SUM_W + 1 - Q_W){1'b0}}, b};
		sat_add = s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
	endfunction

endpackage

/* hw/rtl/wbh_div.sv */
// Restoring divider giving floor(sum * 2^16 / total), one quotient bit per cycle.
`timescale 1ns / 1ps

module wbh_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [wbh_pkg::SUM_W-1:0]     dividend,
	input  logic [wbh_pkg::SUM_W-1:0]     divisor,
	output logic [wbh_pkg::Q_W-1:0]       quotient,
	output logic                          done
);

	logic [wbh_pkg::SUM_W-1:0]     rem_q;
	logic [wbh_pkg::Q_W-1:0]       feed_q;
	logic [wbh_pkg::Q_W-1:0]       quo_q;
	logic [wbh_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                          run_q;
	logic                          done_q;

	logic [wbh_pkg::SUM_W:0]   trial;
	logic [wbh_pkg::SUM_W:0]   diff;
	logic                      take;

	// The sum never exceeds its total, so the quotient fits in seventeen bits and
	// the partial remainder starts below the divisor.
	assign trial = {rem_q, feed_q[wbh_pkg::Q_W-1]};
	assign diff  = trial - {1'b0, divisor};
	assign take  = trial >= {1'b0, divisor};

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= {1'b0, dividend[wbh_pkg::SUM_W-1:1]};
			feed_q <= {dividend[0], {(wbh_pkg::Q_W - 1){1'b0}}};
			quo_q  <= '0;
		end else if (run_q) begin
			rem_q  <= take ? diff[wbh_pkg::SUM_W-1:0] : trial[wbh_pkg::SUM_W-1:0];
			feed_q <= {feed_q[wbh_pkg::Q_W-2:0], 1'b0};
			quo_q  <= {quo_q[wbh_pkg::Q_W-2:0], take};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= wbh_pkg::DIV_CNT_W'(wbh_pkg::DIV_STEPS);
				run_q <= 1'b1;
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == wbh_pkg::DIV_CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

/* hw/rtl/wbh_ctrl.sv */
// Sequencer of the histogram: accepts commands and steps the finalize pass over the bins.
`timescale 1ns / 1ps

module wbh_ctrl #(
	parameter int NUM_BINS = wbh_pkg::DEF_NUM_BINS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  wbh_pkg::sts_t               sts,
	output wbh_pkg::cmd_t               cmd,
	output logic [$clog2(NUM_BINS)-1:0] idx
);

	localparam int BIN_W = $clog2(NUM_BINS);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_EXEC   = 3'd1;
	localparam logic [2:0] S_FRD    = 3'd2;
	localparam logic [2:0] S_FSTART = 3'd3;
	localparam logic [2:0] S_FDIV   = 3'd4;
	localparam logic [2:0] S_FWR    = 3'd5;

	logic [2:0]       state_q, state_d;
	logic [BIN_W-1:0] idx_q, idx_d;
	logic             idx_last;

	assign idx_last = idx_q == BIN_W'(NUM_BINS - 1);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		idx_d   = idx_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.accept = 1'b1;
					cmd.rd_en  = 1'b1;
					if (sts.start_fin && !sts.finalized) begin
						state_d = S_FRD;
						idx_d   = '0;
					end else begin
						state_d = S_EXEC;
					end
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = S_IDLE;
			end
			S_FRD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_fin = 1'b1;
				state_d    = S_FSTART;
			end
			S_FSTART: begin
				cmd.div_start = 1'b1;
				state_d       = S_FDIV;
			end
			S_FDIV: begin
				if (sts.div_done) begin
					state_d = S_FWR;
				end
			end
			S_FWR: begin
				cmd.fin_wr = 1'b1;
				if (idx_last) begin
					cmd.fin_done = 1'b1;
					state_d      = S_IDLE;
				end else begin
					idx_d   = idx_q + 1'b1;
					state_d = S_FRD;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
		end
	end

	assign busy = state_q != S_IDLE;
	assign idx  = idx_q;

endmodule

/* hw/rtl/wbh_dpath.sv */
// Datapath of the histogram: thresholds, bin store, totals, dividers and result registers.
`timescale 1ns / 1ps

module wbh_dpath #(
	parameter int NUM_BINS    = wbh_pkg::DEF_NUM_BINS,
	parameter int COUNT_WIDTH = wbh_pkg::DEF_COUNT_WIDTH
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  wbh_pkg::cmd_t                         cmd,
	input  logic [$clog2(NUM_BINS)-1:0]           idx,
	output wbh_pkg::sts_t                         sts,
	input  logic [wbh_pkg::OP_W-1:0]              operation,
	input  logic signed [wbh_pkg::PROB_W-1:0]     probability,
	input  logic signed [wbh_pkg::VAL_W-1:0]      sample_value,
	input  logic                                  cfg_valid,
	input  logic [wbh_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic signed [wbh_pkg::VAL_W-1:0]      cfg_data,
	output logic                                  done,
	output logic [wbh_pkg::STATUS_W-1:0]          status,
	output logic [wbh_pkg::BIN_OUT_W-1:0]         bin_index,
	output logic [wbh_pkg::SUM_W-1:0]             positive_weight,
	output logic [wbh_pkg::SUM_W-1:0]             negative_weight,
	output logic [wbh_pkg::OUT_COUNT_W-1:0]       item_count,
	output logic                                  is_ready
);

	localparam int BIN_W  = $clog2(NUM_BINS);
	localparam int SUM_W  = wbh_pkg::SUM_W;
	localparam int ENT_W  = COUNT_WIDTH + 2 * SUM_W;
	localparam int CNT_XW = (COUNT_WIDTH > wbh_pkg::OUT_COUNT_W) ? COUNT_WIDTH
	                                                             : wbh_pkg::OUT_COUNT_W;

	// Threshold registers.
	logic signed [wbh_pkg::VAL_W-1:0] th_q [wbh_pkg::NUM_THRESH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < wbh_pkg::NUM_THRESH; i++) begin
				th_q[i] <= wbh_pkg::THRESH_RESET[i];
			end
		end else if (cfg_valid && cfg_index < wbh_pkg::CFG_IDX_W'(wbh_pkg::NUM_THRESH)) begin
			th_q[cfg_index] <= cfg_data;
		end
	end

	// The first threshold that the value does not exceed picks the bin.
	logic [BIN_W-1:0] bin_c;

	always_comb begin
		bin_c = BIN_W'(NUM_BINS - 1);
		for (int i = NUM_BINS - 2; i >= 0; i--) begin
			if (sample_value <= th_q[i]) begin
				bin_c = BIN_W'(i);
			end
		end
	end

	// Command latched at the transfer.
	logic [wbh_pkg::OP_W-1:0]          op_q;
	logic [wbh_pkg::PROB_W-1:0]        prob_q;
	logic [BIN_W-1:0]                  bin_q;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q   <= operation;
			prob_q <= probability;
			bin_q  <= bin_c;
		end
	end

	// Bin store: count, positive sum and negative sum per entry.
	logic [ENT_W-1:0]    mem [NUM_BINS];
	logic [NUM_BINS-1:0] valid_q;
	logic [ENT_W-1:0]    rd_q;
	logic [BIN_W-1:0]    rd_addr;
	logic                wr_en;
	logic [BIN_W-1:0]    wr_addr;
	logic [ENT_W-1:0]    wr_data;

	assign rd_addr = cmd.rd_fin ? idx : bin_c;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// An entry never written reads as zero.
	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rd_q <= valid_q[rd_addr] ? mem[rd_addr] : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	logic [COUNT_WIDTH-1:0] rd_cnt;
	logic [SUM_W-1:0]       rd_pos;
	logic [SUM_W-1:0]       rd_neg;

	assign rd_cnt = rd_q[ENT_W-1 -: COUNT_WIDTH];
	assign rd_pos = rd_q[2*SUM_W-1 -: SUM_W];
	assign rd_neg = rd_q[SUM_W-1:0];

	// Totals and finalized flag.
	logic [SUM_W-1:0] ptot_q;
	logic [SUM_W-1:0] ntot_q;
	logic             fin_q;

	// Insert update.
	logic [wbh_pkg::Q_W-1:0] pp;
	logic [wbh_pkg::Q_W-1:0] np;
	logic                    prob_ok;
	logic                    ins_ok;
	logic [COUNT_WIDTH-1:0]  new_cnt;
	logic [SUM_W-1:0]        new_pos;
	logic [SUM_W-1:0]        new_neg;

	assign pp      = prob_q[wbh_pkg::Q_W-1:0];
	assign np      = wbh_pkg::ONE_Q16 - pp;
	assign prob_ok = !prob_q[wbh_pkg::PROB_W-1] && (pp <= wbh_pkg::ONE_Q16);
	assign ins_ok  = (op_q == wbh_pkg::OP_INSERT) && !fin_q && prob_ok;
	assign new_cnt = (&rd_cnt) ? rd_cnt : rd_cnt + 1'b1;
	assign new_pos = wbh_pkg::sat_add(rd_pos, pp);
	assign new_neg = wbh_pkg::sat_add(rd_neg, np);

	// Dividers, one per side, working on the same entry.
	logic [wbh_pkg::Q_W-1:0] qp;
	logic [wbh_pkg::Q_W-1:0] qn;
	logic                    dp_done;
	logic                    dn_done;
	logic                    ptot_zero;
	logic                    ntot_zero;
	logic [wbh_pkg::Q_W-1:0] qp_m;
	logic [wbh_pkg::Q_W-1:0] qn_m;

	wbh_div u_div_pos (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (rd_pos),
		.divisor  (ptot_q),
		.quotient (qp),
		.done     (dp_done)
	);

	wbh_div u_div_neg (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (rd_neg),
		.divisor  (ntot_q),
		.quotient (qn),
		.done     (dn_done)
	);

	assign ptot_zero = ptot_q == '0;
	assign ntot_zero = ntot_q == '0;
	assign qp_m      = ptot_zero ? '0 : qp;
	assign qn_m      = ntot_zero ? '0 : qn;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = bin_q;
		wr_data = {new_cnt, new_pos, new_neg};
		if (cmd.fin_wr) begin
			wr_en   = 1'b1;
			wr_addr = idx;
			wr_data = {rd_cnt, SUM_W'(qp_m), SUM_W'(qn_m)};
		end else if (cmd.exec && ins_ok) begin
			wr_en = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptot_q <= '0;
			ntot_q <= '0;
			fin_q  <= 1'b0;
		end else begin
			if (cmd.exec && ins_ok) begin
				ptot_q <= wbh_pkg::sat_add(ptot_q, pp);
				ntot_q <= wbh_pkg::sat_add(ntot_q, np);
			end
			if (cmd.fin_done) begin
				fin_q <= 1'b1;
			end
		end
	end

	// Result fields.
	logic [COUNT_WIDTH-1:0]            res_cnt;
	logic [CNT_XW-1:0]                 cnt_x;
	logic [wbh_pkg::OUT_COUNT_W-1:0]   cnt_out;
	logic [wbh_pkg::STATUS_W-1:0]      st_c;

	assign res_cnt = ins_ok ? new_cnt : rd_cnt;
	assign cnt_x   = CNT_XW'(res_cnt);
	assign cnt_out = (cnt_x > CNT_XW'({wbh_pkg::OUT_COUNT_W{1'b1}}))
	               ? {wbh_pkg::OUT_COUNT_W{1'b1}} : cnt_x[wbh_pkg::OUT_COUNT_W-1:0];

	always_comb begin
		priority if (op_q != wbh_pkg::OP_INSERT) begin
			st_c = wbh_pkg::ST_OK;
		end else if (fin_q) begin
			st_c = wbh_pkg::ST_REJECT;
		end else if (!prob_ok) begin
			st_c = wbh_pkg::ST_RANGE;
		end else begin
			st_c = wbh_pkg::ST_OK;
		end
	end

	logic                                done_q;
	logic [wbh_pkg::STATUS_W-1:0]        status_q;
	logic [wbh_pkg::BIN_OUT_W-1:0]       bin_out_q;
	logic [SUM_W-1:0]                    pos_out_q;
	logic [SUM_W-1:0]                    neg_out_q;
	logic [wbh_pkg::OUT_COUNT_W-1:0]     cnt_out_q;
	logic                                rdy_out_q;

	// A finalize that reaches the plain execute step has already been rejected.
	always_ff @(posedge clk) begin
		if (cmd.fin_done || (cmd.exec && op_q == wbh_pkg::OP_FINALIZE)) begin
			status_q  <= cmd.fin_done ? ((ptot_zero || ntot_zero) ? wbh_pkg::ST_ZERO
			                                                      : wbh_pkg::ST_OK)
			                          : wbh_pkg::ST_REJECT;
			bin_out_q <= '0;
			pos_out_q <= '0;
			neg_out_q <= '0;
			cnt_out_q <= '0;
			rdy_out_q <= 1'b1;
		end else if (cmd.exec) begin
			status_q  <= st_c;
			bin_out_q <= wbh_pkg::BIN_OUT_W'(bin_q);
			pos_out_q <= ins_ok ? new_pos : rd_pos;
			neg_out_q <= ins_ok ? new_neg : rd_neg;
			cnt_out_q <= cnt_out;
			rdy_out_q <= fin_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.exec || cmd.fin_done;
		end
	end

	assign sts.start_fin = operation == wbh_pkg::OP_FINALIZE;
	assign sts.finalized = fin_q;
	assign sts.div_done  = dp_done && dn_done;

	assign done            = done_q;
	assign status          = status_q;
	assign bin_index       = bin_out_q;
	assign positive_weight = pos_out_q;
	assign negative_weight = neg_out_q;
	assign item_count      = cnt_out_q;
	assign is_ready        = rdy_out_q;

endmodule

/* hw/rtl/weighted_bin_histogram_model.sv */
// Top level of the weighted bin histogram: sequencer and datapath.
//
// Channel   Direction  Transfer condition          Payload
// command   in         start & !busy               operation, probability, sample_value
// result    out        done (one cycle, no stall)  status, bin_index, positive_weight,
//                                                  negative_weight, item_count, is_ready
// config    in         cfg_valid & cfg_ready       cfg_index, cfg_data
//
// Insert, query and rejected commands read the bin entry at the transfer edge; in the
// execute state that follows, the entry is updated and the result registers are loaded.
// Finalize walks the bins in turn: each bin needs a read, a divider start, seventeen
// restoring division steps, a wait in which the sequencer sees the dividers finish,
// and a write-back.
// busy is high for the whole command; the result register is separate, so a new command
// may be taken in the cycle its predecessor's result is shown. The receiver cannot stall.
// Reset restores the default thresholds and clears all counts, sums and totals at once.
`timescale 1ns / 1ps

module weighted_bin_histogram_model #(
	parameter int NUM_BINS    = wbh_pkg::DEF_NUM_BINS,
	parameter int COUNT_WIDTH = wbh_pkg::DEF_COUNT_WIDTH
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic [wbh_pkg::OP_W-1:0]              operation,
	input  logic signed [wbh_pkg::PROB_W-1:0]     probability,
	input  logic signed [wbh_pkg::VAL_W-1:0]      sample_value,
	output logic                                  done,
	output logic [wbh_pkg::STATUS_W-1:0]          status,
	output logic [wbh_pkg::BIN_OUT_W-1:0]         bin_index,
	output logic [wbh_pkg::SUM_W-1:0]             positive_weight,
	output logic [wbh_pkg::SUM_W-1:0]             negative_weight,
	output logic [wbh_pkg::OUT_COUNT_W-1:0]       item_count,
	output logic                                  is_ready,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [wbh_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic signed [wbh_pkg::VAL_W-1:0]      cfg_data
);

	localparam int BIN_W = $clog2(NUM_BINS);

	wbh_pkg::cmd_t    cmd;
	wbh_pkg::sts_t    sts;
	logic [BIN_W-1:0] idx;

	wbh_ctrl #(
		.NUM_BINS (NUM_BINS)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.cmd    (cmd),
		.idx    (idx)
	);

	wbh_dpath #(
		.NUM_BINS    (NUM_BINS),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.idx             (idx),
		.sts             (sts),
		.operation       (operation),
		.probability     (probability),
		.sample_value    (sample_value),
		.cfg_valid       (cfg_valid),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.done            (done),
		.status          (status),
		.bin_index       (bin_index),
		.positive_weight (positive_weight),
		.negative_weight (negative_weight),
		.item_count      (item_count),
		.is_ready        (is_ready)
	);

	// Threshold writes go straight into the registers, so the port never pushes back.
	assign cfg_ready = 1'b1;

endmodule
